### rtl/blet_pkg.sv
// Shared types and constants for the bucketed LRU eviction table.
// No dependencies; used by every other file in rtl/.
package blet_pkg;

  localparam int unsigned ENTRIES_DEF  = 32;
  localparam int unsigned KEY_BITS_DEF = 32;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned STAMP_W = 64;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned PADDR_W = 4;

  // register index sits at paddr[3] (8-byte registers)
  localparam logic REG_BUCKET_MASK = 1'b0;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_EVICT  = 2'd2
  } blet_mode_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_SAME      = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_FULL      = 3'd5,
    ST_EVICTED   = 3'd6
  } blet_status_e;

  typedef struct packed {
    logic shift;
    logic load;
    logic kill;
  } blet_cell_ctrl_t;

endpackage

### rtl/bucketed_lru_eviction_table_top.sv
// Bucketed LRU eviction table: entries live in a ring of ENTRIES cells that
// rotates one entry per cycle past a single compare unit at the head. A full
// rotation restores the original order. An insert/update or remove item makes
// one full rotation after its transfer, then its result is registered; the
// next item is taken only once the block is back in idle. An evict item shows
// one result per evicted key, with one rotation each to find the oldest entry.
// An evict item with nothing to evict, or an unused mode, needs no rotation
// and gives no result. The rate is set by the ring rotation; a held output
// register stalls the block at the end of a rotation. Depends on blet_pkg and
// blet_cell.
module bucketed_lru_eviction_table_top #(
  parameter int unsigned ENTRIES  = blet_pkg::ENTRIES_DEF,
  parameter int unsigned KEY_BITS = blet_pkg::KEY_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [blet_pkg::PADDR_W-1:0]  paddr,
  input  logic [blet_pkg::DATA_W-1:0]   pwdata,
  output logic [blet_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    mode_i,
  input  logic [blet_pkg::KEY_W-1:0]    key_i,
  input  logic [blet_pkg::STAMP_W-1:0]  stamp_i,
  input  logic [blet_pkg::CNT_W-1:0]    limit_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [blet_pkg::STAT_W-1:0]   status_o,
  output logic [blet_pkg::KEY_W-1:0]    evicted_key_o,
  output logic [blet_pkg::CNT_W-1:0]    evict_count_o,
  output logic [blet_pkg::CNT_W-1:0]    occupancy_o,
  output logic                          last_o
);

  localparam int unsigned KW = (KEY_BITS < blet_pkg::KEY_W) ? KEY_BITS : blet_pkg::KEY_W;
  localparam int unsigned PW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned SW = blet_pkg::STAMP_W;
  localparam int unsigned OW = blet_pkg::CNT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  state_e                  state_q;
  blet_pkg::blet_mode_e    mode_q;
  logic [KW-1:0]           key_q;
  logic [SW-1:0]           stamp_q;
  logic [OW-1:0]           limit_q;
  logic [PW-1:0]           pos_q;
  logic                    found_q;
  blet_pkg::blet_status_e  upd_status_q;
  logic                    free_v_q;
  logic [PW-1:0]           free_pos_q;
  logic                    best_v_q;
  logic [PW-1:0]           best_pos_q;
  logic [KW-1:0]           best_key_q;
  logic [SW-1:0]           best_stamp_q;
  logic [OW-1:0]           ev_n_q;
  logic [CW-1:0]           count_q;
  logic [SW-1:0]           mask_q;

  logic                    out_valid_q;
  blet_pkg::blet_status_e  status_q;
  logic [blet_pkg::KEY_W-1:0] evicted_key_q;
  logic [OW-1:0]           evict_count_q;
  logic [OW-1:0]           occupancy_q;
  logic                    last_q;

  logic                    valid_w [ENTRIES];
  logic [KW-1:0]           key_w   [ENTRIES];
  logic [SW-1:0]           stamp_w [ENTRIES];

  logic                    tail_valid;
  logic [SW-1:0]           tail_stamp;
  logic                    hit;
  logic                    same;
  logic                    older;
  logic                    out_free;
  logic                    do_insert;
  logic                    do_evict;
  logic                    evict_last;
  logic [CW-1:0]           count_dec;
  blet_pkg::blet_mode_e    in_mode;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[3] == blet_pkg::REG_BUCKET_MASK) ? mask_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '1;
    end else if (psel && penable && pwrite && pready &&
                 paddr[3] == blet_pkg::REG_BUCKET_MASK) begin
      mask_q <= pwdata;
    end
  end

  // head compare
  assign hit   = valid_w[0] && (key_w[0] == key_q);
  assign same  = (stamp_w[0] & mask_q) == (stamp_q & mask_q);
  assign older = !best_v_q || (stamp_w[0] < best_stamp_q) ||
                 ((stamp_w[0] == best_stamp_q) && (key_w[0] < best_key_q));

  always_comb begin
    tail_valid = valid_w[0];
    tail_stamp = stamp_w[0];
    if (mode_q == blet_pkg::MODE_INSERT && hit && !same) begin
      tail_stamp = stamp_q;
    end
    if (mode_q == blet_pkg::MODE_REMOVE && hit) begin
      tail_valid = 1'b0;
    end
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign do_insert  = (state_q == S_DONE) && out_free && (mode_q == blet_pkg::MODE_INSERT) &&
                      !found_q && free_v_q;
  assign do_evict   = (state_q == S_DONE) && out_free && (mode_q == blet_pkg::MODE_EVICT) &&
                      best_v_q;
  assign count_dec  = count_q - CW'(1);
  assign evict_last = OW'(count_dec) <= limit_q;
  assign in_mode    = blet_pkg::blet_mode_e'(mode_i);

  // cell ring
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    blet_pkg::blet_cell_ctrl_t ctrl;
    logic                      nv;
    logic [KW-1:0]             nk;
    logic [SW-1:0]             ns;

    assign ctrl.shift = (state_q == S_SCAN);
    assign ctrl.load  = do_insert && (free_pos_q == PW'(i));
    assign ctrl.kill  = do_evict && (best_pos_q == PW'(i));

    if (i == ENTRIES - 1) begin : g_tail
      assign nv = tail_valid;
      assign nk = key_w[0];
      assign ns = tail_stamp;
    end else begin : g_mid
      assign nv = valid_w[i+1];
      assign nk = key_w[i+1];
      assign ns = stamp_w[i+1];
    end

    blet_cell #(
      .KW (KW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .nxt_valid_i (nv),
      .nxt_key_i   (nk),
      .nxt_stamp_i (ns),
      .wr_key_i    (key_q),
      .wr_stamp_i  (stamp_q),
      .valid_o     (valid_w[i]),
      .key_o       (key_w[i]),
      .stamp_o     (stamp_w[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      mode_q        <= blet_pkg::MODE_INSERT;
      key_q         <= '0;
      stamp_q       <= '0;
      limit_q       <= '0;
      pos_q         <= '0;
      found_q       <= 1'b0;
      upd_status_q  <= blet_pkg::ST_SAME;
      free_v_q      <= 1'b0;
      free_pos_q    <= '0;
      best_v_q      <= 1'b0;
      best_pos_q    <= '0;
      best_key_q    <= '0;
      best_stamp_q  <= '0;
      ev_n_q        <= '0;
      count_q       <= '0;
      out_valid_q   <= 1'b0;
      status_q      <= blet_pkg::ST_INSERTED;
      evicted_key_q <= '0;
      evict_count_q <= '0;
      occupancy_q   <= '0;
      last_q        <= 1'b0;
    end else begin
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            mode_q   <= in_mode;
            key_q    <= key_i[KW-1:0];
            stamp_q  <= stamp_i;
            limit_q  <= limit_i;
            pos_q    <= '0;
            found_q  <= 1'b0;
            free_v_q <= 1'b0;
            best_v_q <= 1'b0;
            ev_n_q   <= '0;
            if (in_mode == blet_pkg::MODE_INSERT || in_mode == blet_pkg::MODE_REMOVE) begin
              state_q <= S_SCAN;
            end else if (in_mode == blet_pkg::MODE_EVICT && OW'(count_q) > limit_i) begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          pos_q <= pos_q + PW'(1);
          if (hit) begin
            found_q      <= 1'b1;
            upd_status_q <= same ? blet_pkg::ST_SAME : blet_pkg::ST_UPDATED;
          end
          if (!valid_w[0] && !free_v_q) begin
            free_v_q   <= 1'b1;
            free_pos_q <= pos_q;
          end
          if (valid_w[0] && older) begin
            best_v_q     <= 1'b1;
            best_pos_q   <= pos_q;
            best_key_q   <= key_w[0];
            best_stamp_q <= stamp_w[0];
          end
          if (pos_q == PW'(ENTRIES - 1)) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            evicted_key_q <= (mode_q == blet_pkg::MODE_EVICT) ?
                             blet_pkg::KEY_W'(best_key_q) : '0;
            evict_count_q <= (mode_q == blet_pkg::MODE_EVICT) ? ev_n_q + OW'(1) : '0;
            last_q        <= (mode_q == blet_pkg::MODE_EVICT) ? evict_last : 1'b1;
            state_q       <= (mode_q == blet_pkg::MODE_EVICT && !evict_last) ?
                             S_SCAN : S_IDLE;
            case (mode_q)
              blet_pkg::MODE_INSERT: begin
                if (found_q) begin
                  status_q    <= upd_status_q;
                  occupancy_q <= OW'(count_q);
                end else if (free_v_q) begin
                  status_q    <= blet_pkg::ST_INSERTED;
                  count_q     <= count_q + CW'(1);
                  occupancy_q <= OW'(count_q + CW'(1));
                end else begin
                  status_q    <= blet_pkg::ST_FULL;
                  occupancy_q <= OW'(count_q);
                end
              end
              blet_pkg::MODE_REMOVE: begin
                if (found_q) begin
                  status_q    <= blet_pkg::ST_REMOVED;
                  count_q     <= count_dec;
                  occupancy_q <= OW'(count_dec);
                end else begin
                  status_q    <= blet_pkg::ST_NOT_FOUND;
                  occupancy_q <= OW'(count_q);
                end
              end
              blet_pkg::MODE_EVICT: begin
                status_q    <= blet_pkg::ST_EVICTED;
                ev_n_q      <= ev_n_q + OW'(1);
                count_q     <= count_dec;
                occupancy_q <= OW'(count_dec);
                pos_q       <= '0;
                best_v_q    <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign evicted_key_o = evicted_key_q;
  assign evict_count_o = evict_count_q;
  assign occupancy_o   = occupancy_q;
  assign last_o        = last_q;

endmodule

### rtl/blet_cell.sv
// One table cell: valid bit, key and stamp; shifts toward the head of the ring.
// Depends on blet_pkg.
module blet_cell #(
  parameter int unsigned KW = blet_pkg::KEY_W
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  blet_pkg::blet_cell_ctrl_t   ctrl_i,
  input  logic                        nxt_valid_i,
  input  logic [KW-1:0]               nxt_key_i,
  input  logic [blet_pkg::STAMP_W-1:0] nxt_stamp_i,
  input  logic [KW-1:0]               wr_key_i,
  input  logic [blet_pkg::STAMP_W-1:0] wr_stamp_i,
  output logic                        valid_o,
  output logic [KW-1:0]               key_o,
  output logic [blet_pkg::STAMP_W-1:0] stamp_o
);

  logic                         valid_q;
  logic [KW-1:0]                key_q;
  logic [blet_pkg::STAMP_W-1:0] stamp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      valid_q <= nxt_valid_i;
    end else if (ctrl_i.load) begin
      valid_q <= 1'b1;
    end else if (ctrl_i.kill) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      key_q   <= nxt_key_i;
      stamp_q <= nxt_stamp_i;
    end else if (ctrl_i.load) begin
      key_q   <= wr_key_i;
      stamp_q <= wr_stamp_i;
    end
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign stamp_o = stamp_q;

endmodule

### rtl/blet_checker.sv
// Port-level checks for the bucketed LRU eviction table, bound to the top level.
// Depends on blet_pkg and bucketed_lru_eviction_table_top.
module blet_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [blet_pkg::STAT_W-1:0] status_o,
  input logic [blet_pkg::KEY_W-1:0]  evicted_key_o,
  input logic [blet_pkg::CNT_W-1:0]  evict_count_o,
  input logic [blet_pkg::CNT_W-1:0]  occupancy_o,
  input logic                        last_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
    $stable(evicted_key_o) && $stable(occupancy_o))
    else $error("result changed while stalled");

  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != blet_pkg::ST_EVICTED |->
    last_o && evicted_key_o == '0 && evict_count_o == '0)
    else $error("non-evict result not a single final transfer");

  a_evcnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == blet_pkg::ST_EVICTED |-> evict_count_o != '0)
    else $error("evict transfer with zero count");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= blet_pkg::ST_EVICTED)
    else $error("unused status code");

  a_evseq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && status_o == blet_pkg::ST_EVICTED && !last_o ##1
    out_valid_o |-> status_o == blet_pkg::ST_EVICTED &&
    evict_count_o == $past(evict_count_o) + 7'd1)
    else $error("eviction sequence broken");

endmodule

bind bucketed_lru_eviction_table_top blet_checker u_blet_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .status_o      (status_o),
  .evicted_key_o (evicted_key_o),
  .evict_count_o (evict_count_o),
  .occupancy_o   (occupancy_o),
  .last_o        (last_o)
);

### tb/tb_bucketed_lru_eviction_table_top.sv
// Self-checking testbench for bucketed_lru_eviction_table_top: a directed table, then random
// phases under several bucket masks; results are checked against an in-bench table model,
// typed directed rows against the table's own values. Depends on blet_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_bucketed_lru_eviction_table_top;

  localparam int unsigned   N_ENT       = blet_pkg::ENTRIES_DEF;
  localparam logic [1:0]    MODE_UNUSED = 2'd3;
  localparam logic [blet_pkg::PADDR_W-1:0] MASK_ADDR = {blet_pkg::REG_BUCKET_MASK, 3'b000};
  localparam int            PHASE_ITEMS = 35;
  localparam int            N_PHASES    = 7;

  typedef struct {
    blet_pkg::blet_status_e          status;
    logic [blet_pkg::KEY_W-1:0]      ekey;
    logic [blet_pkg::CNT_W-1:0]      ecount;
    logic [blet_pkg::CNT_W-1:0]      occ;
    logic                            last;
  } result_t;

  typedef struct packed {
    logic [1:0]                      mode;
    logic [blet_pkg::KEY_W-1:0]      key;
    logic [blet_pkg::STAMP_W-1:0]    stamp;
    logic [blet_pkg::CNT_W-1:0]      limit;
    logic [5:0]                      rep;
    logic                            typed;
    logic [blet_pkg::STAT_W-1:0]     st;
    logic [blet_pkg::CNT_W-1:0]      occ;
  } dir_row_t;

  localparam int N_ROWS = 22;
  localparam dir_row_t DIR_TAB [N_ROWS] = '{
    '{blet_pkg::MODE_REMOVE, 32'd5, 64'd0,
      7'd0, 6'd1, 1'b1, blet_pkg::ST_NOT_FOUND, 7'd0},
    '{blet_pkg::MODE_EVICT, 32'd0, 64'd0,
      7'd0, 6'd1, 1'b0, blet_pkg::ST_EVICTED, 7'd0},
    '{MODE_UNUSED, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
      7'd64, 6'd1, 1'b0, blet_pkg::ST_EVICTED, 7'd0},
    '{blet_pkg::MODE_INSERT, 32'd0, 64'd0,
      7'd0, 6'd1, 1'b1, blet_pkg::ST_INSERTED, 7'd1},
    '{blet_pkg::MODE_INSERT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
      7'd0, 6'd1, 1'b1, blet_pkg::ST_INSERTED, 7'd2},
    '{blet_pkg::MODE_INSERT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
      7'd0, 6'd1, 1'b1, blet_pkg::ST_SAME, 7'd2},
    '{blet_pkg::MODE_INSERT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE,
      7'd0, 6'd1, 1'b1, blet_pkg::ST_UPDATED, 7'd2},
    '{blet_pkg::MODE_INSERT, 32'd0, 64'd0,
      7'd0, 6'd1, 1'b1, blet_pkg::ST_SAME, 7'd2},
    '{blet_pkg::MODE_INSERT, 32'h100, 64'h1000,
      7'd0, 6'd30, 1'b0, blet_pkg::ST_INSERTED, 7'd0},
    '{blet_pkg::MODE_INSERT, 32'hDEAD_BEEF, 64'd5,
      7'd0, 6'd1, 1'b1, blet_pkg::ST_FULL, 7'd32},
    '{blet_pkg::MODE_REMOVE, 32'd0, 64'd0,
      7'd0, 6'd1, 1'b1, blet_pkg::ST_REMOVED, 7'd31},
    '{blet_pkg::MODE_INSERT, 32'hFFFF_FFFF, 64'd0,
      7'd0, 6'd1, 1'b1, blet_pkg::ST_UPDATED, 7'd31},
    '{blet_pkg::MODE_INSERT, 32'h100, 64'd0,
      7'd0, 6'd1, 1'b1, blet_pkg::ST_UPDATED, 7'd31},
    '{blet_pkg::MODE_EVICT, 32'd0, 64'd0,
      7'd64, 6'd1, 1'b0, blet_pkg::ST_EVICTED, 7'd0},
    '{blet_pkg::MODE_EVICT, 32'd0, 64'd0,
      7'd29, 6'd1, 1'b0, blet_pkg::ST_EVICTED, 7'd0},
    '{blet_pkg::MODE_INSERT, 32'd1, 64'h8000_0000_0000_0000,
      7'd0, 6'd1, 1'b1, blet_pkg::ST_INSERTED, 7'd30},
    '{blet_pkg::MODE_REMOVE, 32'h1234, 64'd0,
      7'd0, 6'd1, 1'b1, blet_pkg::ST_NOT_FOUND, 7'd30},
    '{MODE_UNUSED, 32'd0, 64'd0,
      7'd0, 6'd1, 1'b0, blet_pkg::ST_EVICTED, 7'd0},
    '{blet_pkg::MODE_EVICT, 32'd0, 64'd0,
      7'd0, 6'd1, 1'b0, blet_pkg::ST_EVICTED, 7'd0},
    '{blet_pkg::MODE_INSERT, 32'hA5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A,
      7'd0, 6'd1, 1'b1, blet_pkg::ST_INSERTED, 7'd1},
    '{blet_pkg::MODE_EVICT, 32'd0, 64'd0,
      7'd1, 6'd1, 1'b0, blet_pkg::ST_EVICTED, 7'd0},
    '{blet_pkg::MODE_REMOVE, 32'hA5A5_A5A5, 64'd0,
      7'd0, 6'd1, 1'b1, blet_pkg::ST_REMOVED, 7'd0}
  };

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            psel, penable, pwrite;
  logic [blet_pkg::PADDR_W-1:0]    paddr;
  logic [blet_pkg::DATA_W-1:0]     pwdata;
  logic [blet_pkg::DATA_W-1:0]     prdata;
  logic                            pready;
  logic                            in_valid_i;
  logic                            in_ready_o;
  logic [1:0]                      mode_i;
  logic [blet_pkg::KEY_W-1:0]      key_i;
  logic [blet_pkg::STAMP_W-1:0]    stamp_i;
  logic [blet_pkg::CNT_W-1:0]      limit_i;
  logic                            out_valid_o;
  logic                            out_ready_i;
  logic [blet_pkg::STAT_W-1:0]     status_o;
  logic [blet_pkg::KEY_W-1:0]      evicted_key_o;
  logic [blet_pkg::CNT_W-1:0]      evict_count_o;
  logic [blet_pkg::CNT_W-1:0]      occupancy_o;
  logic                            last_o;

  // table model state
  logic                            mdl_valid [N_ENT];
  logic [blet_pkg::KEY_W-1:0]      mdl_key   [N_ENT];
  logic [blet_pkg::STAMP_W-1:0]    mdl_stamp [N_ENT];
  int                              mdl_count;
  logic [blet_pkg::STAMP_W-1:0]    mdl_mask;

  result_t pending_results [$];
  result_t head_res;
  int      errors;

  bit      tx_steady;
  bit      stall_req;
  int      rx_hold, rx_burst;
  bit      rx_steady;
  logic [blet_pkg::KEY_W-1:0]      pool_base;
  int                              pool_n;
  logic [blet_pkg::STAMP_W-1:0]    stamp_base;

  always #6 clk_i = ~clk_i;

  bucketed_lru_eviction_table_top dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .mode_i, .key_i, .stamp_i, .limit_i,
    .out_valid_o, .out_ready_i, .status_o, .evicted_key_o, .evict_count_o,
    .occupancy_o, .last_o
  );

  function automatic void table_model_apply(logic [1:0] mode,
                                            logic [blet_pkg::KEY_W-1:0] key,
                                            logic [blet_pkg::STAMP_W-1:0] stamp,
                                            logic [blet_pkg::CNT_W-1:0] limit);
    result_t r;
    int hit;
    int slot;
    int best;
    int n;
    r = '{blet_pkg::ST_INSERTED, '0, '0, '0, 1'b1};
    hit = -1;
    slot = -1;
    for (int i = 0; i < N_ENT; i++) begin
      if (hit < 0 && mdl_valid[i] && mdl_key[i] == key) hit = i;
      if (slot < 0 && !mdl_valid[i]) slot = i;
    end
    case (mode)
      blet_pkg::MODE_INSERT: begin
        if (hit >= 0) begin
          if ((mdl_stamp[hit] & mdl_mask) == (stamp & mdl_mask)) begin
            r.status = blet_pkg::ST_SAME;
          end else begin
            mdl_stamp[hit] = stamp;
            r.status = blet_pkg::ST_UPDATED;
          end
        end else if (slot < 0) begin
          r.status = blet_pkg::ST_FULL;
        end else begin
          mdl_valid[slot] = 1'b1;
          mdl_key[slot] = key;
          mdl_stamp[slot] = stamp;
          mdl_count++;
          r.status = blet_pkg::ST_INSERTED;
        end
        r.occ = blet_pkg::CNT_W'(mdl_count);
        pending_results.push_back(r);
      end
      blet_pkg::MODE_REMOVE: begin
        if (hit >= 0) begin
          mdl_valid[hit] = 1'b0;
          mdl_count--;
          r.status = blet_pkg::ST_REMOVED;
        end else begin
          r.status = blet_pkg::ST_NOT_FOUND;
        end
        r.occ = blet_pkg::CNT_W'(mdl_count);
        pending_results.push_back(r);
      end
      blet_pkg::MODE_EVICT: begin
        n = 0;
        while (mdl_count > int'(limit)) begin
          best = -1;
          for (int i = 0; i < N_ENT; i++) begin
            if (mdl_valid[i] && (best < 0 || mdl_stamp[i] < mdl_stamp[best] ||
                (mdl_stamp[i] == mdl_stamp[best] && mdl_key[i] < mdl_key[best])))
              best = i;
          end
          mdl_valid[best] = 1'b0;
          mdl_count--;
          n++;
          r.status = blet_pkg::ST_EVICTED;
          r.ekey = mdl_key[best];
          r.ecount = blet_pkg::CNT_W'(n);
          r.occ = blet_pkg::CNT_W'(mdl_count);
          r.last = (mdl_count <= int'(limit));
          pending_results.push_back(r);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [blet_pkg::STAMP_W-1:0] pick_stamp();
    logic [blet_pkg::STAMP_W-1:0] s;
    case ($urandom_range(0, 5))
      0: s = blet_pkg::STAMP_W'($urandom_range(0, 15));
      1: s = 64'hFFFF_FFFF_FFFF_FFFF - blet_pkg::STAMP_W'($urandom_range(0, 15));
      2, 3: s = stamp_base + blet_pkg::STAMP_W'($urandom_range(0, 511));
      4: s = {$urandom, $urandom};
      default: s = stamp_base + {30'd0, 2'($urandom_range(0, 3)), 32'd0};
    endcase
    return s;
  endfunction

  // one input transfer; entered and left at a falling edge
  task automatic send_item(logic [1:0] mode, logic [blet_pkg::KEY_W-1:0] key,
                           logic [blet_pkg::STAMP_W-1:0] stamp,
                           logic [blet_pkg::CNT_W-1:0] limit);
    int r;
    int gap;
    r = $urandom_range(0, 99);
    if (tx_steady || r < 50) gap = 0;
    else if (r < 85) gap = $urandom_range(1, 3);
    else if (r < 97) gap = $urandom_range(4, 12);
    else gap = $urandom_range(30, 80);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    mode_i = mode;
    key_i = key;
    stamp_i = stamp;
    limit_i = limit;
    do @(posedge clk_i); while (!in_ready_o);
    table_model_apply(mode, key, stamp, limit);
    @(negedge clk_i);
  endtask

  task automatic set_bucket_mask(logic [blet_pkg::DATA_W-1:0] val);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = MASK_ADDR;
    pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    mdl_mask = val;
    @(negedge clk_i);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== val) begin
      $error("bucket_mask readback: expected %h, actual %h", val, prdata);
      errors++;
    end
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (N_ENT + 8) @(negedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d evicted_key %h", status_o, evicted_key_o);
        errors++;
      end else begin
        head_res = pending_results.pop_front();
        if (status_o !== head_res.status) begin
          $error("status: expected %0d, actual %0d", head_res.status, status_o);
          errors++;
        end
        if (evicted_key_o !== head_res.ekey) begin
          $error("evicted_key: expected %h, actual %h", head_res.ekey, evicted_key_o);
          errors++;
        end
        if (evict_count_o !== head_res.ecount) begin
          $error("evict_count: expected %0d, actual %0d", head_res.ecount, evict_count_o);
          errors++;
        end
        if (occupancy_o !== head_res.occ) begin
          $error("occupancy: expected %0d, actual %0d", head_res.occ, occupancy_o);
          errors++;
        end
        if (last_o !== head_res.last) begin
          $error("last: expected %0d, actual %0d", head_res.last, last_o);
          errors++;
        end
      end
    end
  end

  // result receiver: random back-pressure, steady stretches, requested long hold-off
  initial begin
    out_ready_i = 1'b0;
    rx_hold = 0;
    rx_burst = 0;
    rx_steady = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_req) begin
        stall_req = 1'b0;
        rx_hold = 400;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready_i = 1'b0;
      end else begin
        if (rx_burst == 0) begin
          rx_burst = $urandom_range(20, 120);
          rx_steady = ($urandom_range(0, 3) == 0);
        end
        rx_burst--;
        if (rx_steady) begin
          out_ready_i = 1'b1;
        end else if ($urandom_range(0, 39) == 0) begin
          rx_hold = $urandom_range(15, 60);
          out_ready_i = 1'b0;
        end else begin
          out_ready_i = ($urandom_range(0, 99) < 70);
        end
      end
    end
  end

  initial begin
    #150_000_000;
    $display("** bucketed_lru_eviction_table_top: FAILED **");
    $finish;
  end

  initial begin
    logic [blet_pkg::DATA_W-1:0] masks [N_PHASES];
    logic [1:0]                  m;
    logic [blet_pkg::KEY_W-1:0]  k;
    logic [blet_pkg::CNT_W-1:0]  lim;
    int                          sent;
    int                          r;
    errors = 0;
    stall_req = 1'b0;
    tx_steady = 1'b0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    mode_i = blet_pkg::MODE_INSERT;
    key_i = '0;
    stamp_i = '0;
    limit_i = '0;
    for (int i = 0; i < N_ENT; i++) begin
      mdl_valid[i] = 1'b0;
      mdl_key[i] = '0;
      mdl_stamp[i] = '0;
    end
    mdl_count = 0;
    mdl_mask = '1;
    masks[0] = 64'hFFFF_FFFF_FFFF_FFFF;
    masks[1] = 64'h0;
    masks[2] = 64'hFFFF_FFFF_FFFF_FF00;
    masks[3] = {$urandom, $urandom};
    masks[4] = 64'hFFFF_FFFF_0000_0000;
    masks[5] = 64'h0000_0000_FFFF_FFFF;
    masks[6] = 64'hFFFF_FFFF_FFFF_F000;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int row = 0; row < N_ROWS; row++) begin
      for (int j = 0; j < int'(DIR_TAB[row].rep); j++)
        send_item(DIR_TAB[row].mode, DIR_TAB[row].key + blet_pkg::KEY_W'(j),
                  DIR_TAB[row].stamp + blet_pkg::STAMP_W'(j), DIR_TAB[row].limit);
      if (DIR_TAB[row].typed)
        pending_results[pending_results.size() - 1] =
          '{blet_pkg::blet_status_e'(DIR_TAB[row].st), '0, '0, DIR_TAB[row].occ, 1'b1};
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_idle();
      set_bucket_mask(masks[ph]);
      pool_base = $urandom;
      case ($urandom_range(0, 2))
        0: pool_n = 8;
        1: pool_n = 24;
        default: pool_n = 44;
      endcase
      stamp_base = {$urandom, $urandom};
      tx_steady = (ph == 2) || ($urandom_range(0, 3) == 0);
      if (ph == 2) stall_req = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 55) m = blet_pkg::MODE_INSERT;
        else if (r < 75) m = blet_pkg::MODE_REMOVE;
        else if (r < 95) m = blet_pkg::MODE_EVICT;
        else m = MODE_UNUSED;
        if ($urandom_range(0, 19) == 0) k = $urandom;
        else k = pool_base + blet_pkg::KEY_W'($urandom_range(0, pool_n - 1));
        case ($urandom_range(0, 7))
          0: lim = '0;
          1: lim = 7'd64;
          2: lim = blet_pkg::CNT_W'($urandom_range(0, 64));
          default: lim = (mdl_count > 3) ?
                         blet_pkg::CNT_W'(mdl_count - $urandom_range(0, 3)) : '0;
        endcase
        send_item(m, k, pick_stamp(), lim);
        if (m != MODE_UNUSED) sent++;
      end
    end

    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (2 * N_ENT + 8) @(negedge clk_i);
    if (errors == 0 && pending_results.size() == 0)
      $display("** bucketed_lru_eviction_table_top: PASSED **");
    else
      $display("** bucketed_lru_eviction_table_top: FAILED **");
    $finish;
  end

endmodule
